// ===== rtl/link_quality_neighbor_table_macros.svh =====
// Assertion macros for the link-quality neighbour table, clocked on clk and quiet in reset.
`ifndef LINK_QUALITY_NEIGHBOR_TABLE_MACROS_SVH
`define LINK_QUALITY_NEIGHBOR_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LQNT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LQNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lqnt_pkg.sv =====
// Package with the types, codes, constants and capacity table of the neighbour table.
package lqnt_pkg;

  // Sizes fixed by the interface.
  localparam int unsigned DEFAULT_ENTRIES = 16;
  localparam int unsigned ADDR_W          = 48;
  localparam int unsigned TICK_W          = 32;
  localparam int unsigned LOSS_W          = 16;
  localparam int unsigned CAP_W           = 17;
  localparam int unsigned INDEX_W         = 4;
  localparam int unsigned COUNT_W         = 5;
  localparam int unsigned CFG_INDEX_W     = 2;
  localparam int unsigned CFG_DATA_W      = 32;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_A_W = 20;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Division by ten as a multiply by ceil(2^22/10), exact for dividends below 699050.
  localparam logic [MUL_B_W-1:0] RECIP_10    = 32'd419431;
  localparam int unsigned        RECIP_SHIFT = 22;

  // Loss filter constants: a lost exchange adds one whole unit of 65536.
  localparam logic [MUL_A_W-1:0] LOSS_STEP = 20'd65536;
  localparam logic [LOSS_W-1:0]  LOSS_MAX  = 16'hFFFF;
  localparam logic [CAP_W-1:0]   CAP_ONE   = 17'd65536;

  // Register reset values.
  localparam logic [TICK_W-1:0] WINDOW_RESET = 32'd10000;
  localparam logic [7:0]        NOISE_RESET  = 8'hA1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_RECENCY_WINDOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NOISE_FLOOR    = 2'd1;

  // Commands.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_BEST     = 3'd3,
    ST_NONE     = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LOSS_MUL,
    S_CAP_MUL,
    S_WRITE,
    S_FETCH,
    S_SEL_DONE,
    S_EMPTY
  } state_t;

  // One input item.
  typedef struct packed {
    logic                    command;
    logic [ADDR_W-1:0]       neighbor_address;
    logic signed [7:0]       signal_dbm;
    logic                    delivered;
    logic [TICK_W-1:0]       now_tick;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [2:0]              status;
    logic [INDEX_W-1:0]      entry_index;
    logic [ADDR_W-1:0]       entry_address;
    logic signed [7:0]       smoothed_dbm;
    logic [LOSS_W-1:0]       loss_rate;
    logic [CAP_W-1:0]        capacity;
    logic [COUNT_W-1:0]      entry_count;
  } rsp_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [ADDR_W-1:0]       address;
    logic signed [7:0]       level;
    logic [LOSS_W-1:0]       loss;
    logic [CAP_W-1:0]        capacity;
    logic [TICK_W-1:0]       tick;
  } entry_t;

  // Normalised capacity min(1, log2(1 + 10^(snr/10)) / 10) in Q1.16 over SNR in dB.
  function automatic logic [CAP_W-1:0] capacity_rom(input logic [4:0] snr);
    logic [CAP_W-1:0] value;
    case (snr)
      5'd0:    value = 17'd6554;
      5'd1:    value = 17'd7705;
      5'd2:    value = 17'd8979;
      5'd3:    value = 17'd10372;
      5'd4:    value = 17'd11877;
      5'd5:    value = 17'd13483;
      5'd6:    value = 17'd15181;
      5'd7:    value = 17'd16959;
      5'd8:    value = 17'd18807;
      5'd9:    value = 17'd20715;
      5'd10:   value = 17'd22672;
      5'd11:   value = 17'd24670;
      5'd12:   value = 17'd26703;
      5'd13:   value = 17'd28764;
      5'd14:   value = 17'd30848;
      5'd15:   value = 17'd32950;
      5'd16:   value = 17'd35067;
      5'd17:   value = 17'd37197;
      5'd18:   value = 17'd39336;
      5'd19:   value = 17'd41482;
      5'd20:   value = 17'd43635;
      5'd21:   value = 17'd45793;
      5'd22:   value = 17'd47955;
      5'd23:   value = 17'd50120;
      5'd24:   value = 17'd52287;
      5'd25:   value = 17'd54456;
      5'd26:   value = 17'd56627;
      5'd27:   value = 17'd58799;
      5'd28:   value = 17'd60972;
      5'd29:   value = 17'd63146;
      5'd30:   value = 17'd65321;
      default: value = 17'd65536;
    endcase
    return value;
  endfunction

endpackage

// ===== rtl/link_quality_neighbor_table.sv =====
// Link-quality neighbour table: entry memory, scan sequencer and shared multiplier.
//
// Keeps up to NEIGHBOR_ENTRIES neighbours in one memory with a single registered read
// port. An update walks the held entries one per cycle until the address matches or
// the held entries run out; it then works out the smoothed level, the loss estimate
// and the capacity of the matched or newly appended entry in the states S_LOSS_MUL,
// S_CAP_MUL and S_WRITE, or reports ST_FULL when the table is full and the address
// is new. A select streams every held entry through age, multiply and compare stages
// and re-reads the winner, or reports ST_NONE when no entry scores above zero. The one
// memory read per cycle sets the scan time. One item is worked on at a time; req_stall
// stays high until the result sits in the output register, which may wait there while
// the next item is taken. Configuration writes take effect at once and should only be
// made while no item is in progress.
`include "link_quality_neighbor_table_macros.svh"

module link_quality_neighbor_table #(
  parameter int unsigned NEIGHBOR_ENTRIES = lqnt_pkg::DEFAULT_ENTRIES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [lqnt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lqnt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  lqnt_pkg::req_t                       req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output lqnt_pkg::rsp_t                       rsp
);

  import lqnt_pkg::*;

  localparam int unsigned IW = (NEIGHBOR_ENTRIES > 1) ? $clog2(NEIGHBOR_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(NEIGHBOR_ENTRIES + 1);
  localparam int unsigned SCORE_W = CAP_W + TICK_W;

  // Control state.
  state_t              state;
  state_t              state_next;
  logic [CW-1:0]       used;
  logic [CW-1:0]       used_next;
  logic [CW-1:0]       rd_ptr;
  logic                v0;
  logic                v1;
  logic                v2;
  logic                found;

  // Configuration registers.
  logic [TICK_W-1:0]   window;
  logic [7:0]          noise;

  // Item and working registers.
  req_t                item;
  status_t             res_status;
  entry_t              ent;
  logic [IW-1:0]       ent_idx;
  logic [LOSS_W-1:0]   loss_r;
  logic [IW-1:0]       idx0;
  logic [IW-1:0]       idx1;
  logic [IW-1:0]       idx2;
  logic [TICK_W-1:0]   rec_r;
  logic [CAP_W-1:0]    cap_r;
  logic [SCORE_W-1:0]  top_score;
  logic [IW-1:0]       best_idx;
  logic [MUL_P_W-1:0]  prod;

  // Entry memory and its read register.
  entry_t              mem [NEIGHBOR_ENTRIES];
  entry_t              q;

  // Sequencer outputs.
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic                mem_we;
  logic                mul_en;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic                rsp_load;
  rsp_t                rsp_next;

  // Datapath terms.
  logic                out_free;
  logic                issue;
  logic                hit;
  logic                upd_end;
  logic                sel_end;
  logic                full;
  logic signed [10:0]  old_ext;
  logic signed [10:0]  sum_c;
  logic signed [10:0]  adj_c;
  logic signed [10:0]  lvl_c;
  logic signed [7:0]   level_new;
  logic [MUL_A_W-1:0]  loss_x;
  logic [MUL_P_W-1:0]  quot_c;
  logic [LOSS_W-1:0]   loss_new;
  logic signed [9:0]   snr_c;
  logic [4:0]          snr_idx;
  logic [TICK_W-1:0]   age_c;
  logic [TICK_W-1:0]   rec_c;
  logic [CAP_W-1:0]    cap_new;
  entry_t              rec_w;

  // Handshake and scan status terms.
  always_comb begin
    out_free = !rsp_valid || !rsp_stall;
    full     = (used == CW'(NEIGHBOR_ENTRIES));
    issue    = (state == S_SCAN) && (rd_ptr < used);
    hit      = v0 && (q.address == item.neighbor_address);
    upd_end  = (rd_ptr == used) && !v0;
    sel_end  = (rd_ptr == used) && !v0 && !v1 && !v2;
  end

  // Smoothed level: (old*7 + signal)/8, rounded toward zero.
  always_comb begin
    old_ext   = $signed({{3{ent.level[7]}}, ent.level});
    sum_c     = (old_ext <<< 3) - old_ext + $signed({{3{item.signal_dbm[7]}}, item.signal_dbm});
    adj_c     = sum_c + (sum_c[10] ? 11'sd7 : 11'sd0);
    lvl_c     = adj_c >>> 3;
    level_new = lvl_c[7:0];
  end

  // Loss dividend, quotient from the product, and the SNR table index.
  always_comb begin
    loss_x   = ({4'b0, ent.loss} << 3) + {4'b0, ent.loss}
               + (item.delivered ? '0 : LOSS_STEP);
    quot_c   = prod >> RECIP_SHIFT;
    loss_new = (quot_c > MUL_P_W'(LOSS_MAX)) ? LOSS_MAX : quot_c[LOSS_W-1:0];
    snr_c    = $signed({{2{ent.level[7]}}, ent.level}) - $signed({{2{noise[7]}}, noise});
    if (snr_c < 10'sd0) begin
      snr_idx = 5'd0;
    end else if (snr_c > 10'sd31) begin
      snr_idx = 5'd31;
    end else begin
      snr_idx = snr_c[4:0];
    end
    cap_new  = prod[CAP_W+15:16];
  end

  // Remaining recency of the entry in the read register.
  always_comb begin
    age_c = item.now_tick - q.tick;
    rec_c = (age_c < window) ? (window - age_c) : '0;
  end

  // Record written back on an update and the entry count after it.
  always_comb begin
    rec_w          = ent;
    rec_w.loss     = loss_r;
    rec_w.capacity = cap_new;
    rec_w.tick     = item.now_tick;
    used_next      = used;
    if (mem_we && (res_status == ST_INSERTED)) begin
      used_next = used + 1'b1;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (item.command == CMD_SELECT) begin
          if (sel_end) begin
            state_next = found ? S_FETCH : S_EMPTY;
          end
        end else if (hit) begin
          state_next = S_LOSS_MUL;
        end else if (upd_end) begin
          state_next = full ? S_EMPTY : S_LOSS_MUL;
        end
      end
      S_LOSS_MUL: state_next = S_CAP_MUL;
      S_CAP_MUL:  state_next = S_WRITE;
      S_FETCH:    state_next = S_SEL_DONE;
      S_WRITE, S_SEL_DONE, S_EMPTY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: memory port, multiplier operands and result loading.
  always_comb begin
    req_stall = (state != S_IDLE);
    rd_en     = 1'b0;
    rd_addr   = rd_ptr[IW-1:0];
    mem_we    = 1'b0;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    rsp_load  = 1'b0;
    rsp_next  = '0;
    rsp_next.entry_count = COUNT_W'(used);
    case (state)
      S_SCAN: begin
        rd_en  = issue;
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(cap_r);
        mul_b  = rec_r;
      end
      S_LOSS_MUL: begin
        mul_en = 1'b1;
        mul_a  = loss_x;
        mul_b  = RECIP_10;
      end
      S_CAP_MUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(capacity_rom(snr_idx));
        mul_b  = MUL_B_W'(CAP_ONE - {1'b0, loss_new});
      end
      S_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = best_idx;
      end
      S_WRITE: begin
        mem_we   = out_free;
        rsp_load = out_free;
        rsp_next.status        = res_status;
        rsp_next.entry_index   = INDEX_W'(ent_idx);
        rsp_next.entry_address = ent.address;
        rsp_next.smoothed_dbm  = ent.level;
        rsp_next.loss_rate     = loss_r;
        rsp_next.capacity      = cap_new;
        rsp_next.entry_count   = COUNT_W'(used_next);
      end
      S_SEL_DONE: begin
        rsp_load = out_free;
        rsp_next.status        = ST_BEST;
        rsp_next.entry_index   = INDEX_W'(best_idx);
        rsp_next.entry_address = q.address;
        rsp_next.smoothed_dbm  = q.level;
        rsp_next.loss_rate     = q.loss;
        rsp_next.capacity      = q.capacity;
      end
      S_EMPTY: begin
        rsp_load        = out_free;
        rsp_next.status = res_status;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      rd_ptr    <= '0;
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      if (state == S_SCAN) begin
        v0 <= issue;
        v1 <= v0;
        v2 <= v1;
        if (issue) begin
          rd_ptr <= rd_ptr + 1'b1;
        end
        if (v2 && (prod[SCORE_W-1:0] > top_score)) begin
          found <= 1'b1;
        end
      end else begin
        v0 <= 1'b0;
        v1 <= 1'b0;
        v2 <= 1'b0;
        if (state == S_IDLE) begin
          rd_ptr <= '0;
          found  <= 1'b0;
        end
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
      noise  <= NOISE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RECENCY_WINDOW: window <= cfg_data;
        CFG_NOISE_FLOOR:    noise  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Shared multiplier with its product register.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ent_idx] <= rec_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  // Item capture, scan pipeline and per-item working registers.
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item      <= req;
      top_score <= '0;
      best_idx  <= '0;
    end
    case (state)
      S_SCAN: begin
        idx0  <= rd_ptr[IW-1:0];
        idx1  <= idx0;
        idx2  <= idx1;
        rec_r <= rec_c;
        cap_r <= q.capacity;
        if (v2 && (prod[SCORE_W-1:0] > top_score)) begin
          top_score <= prod[SCORE_W-1:0];
          best_idx  <= idx2;
        end
        if (item.command == CMD_SELECT) begin
          res_status <= found ? ST_BEST : ST_NONE;
        end else if (hit) begin
          ent        <= q;
          ent_idx    <= idx0;
          res_status <= ST_UPDATED;
        end else if (upd_end) begin
          if (full) begin
            res_status <= ST_FULL;
          end else begin
            ent.address  <= item.neighbor_address;
            ent.level    <= '0;
            ent.loss     <= '0;
            ent.capacity <= '0;
            ent.tick     <= item.now_tick;
            ent_idx      <= used[IW-1:0];
            res_status   <= ST_INSERTED;
          end
        end
      end
      S_LOSS_MUL: begin
        ent.level <= level_new;
      end
      S_CAP_MUL: begin
        loss_r <= loss_new;
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // The table never holds more entries than it has room for.
  `LQNT_ASSERT_NOW(a_used_bound, 1'b1, used <= CW'(NEIGHBOR_ENTRIES), "entry count overflow")
  // A reported best entry always has a non-zero capacity.
  `LQNT_ASSERT_NOW(a_best_nonzero, rsp_valid && (rsp.status == ST_BEST), rsp.capacity != '0, "best entry with zero capacity")
  // Writing back a new entry grows the table by exactly one.
  `LQNT_ASSERT_NEXT(a_insert_grows, mem_we && (res_status == ST_INSERTED), used == $past(used) + 1'b1, "insert did not grow table")

endmodule
